// File: design/ehpd_pkg.sv
// ============================================================================
// ehpd_pkg
// Shared types and constants for the extreme high PEEP detector.
// ============================================================================
package ehpd_pkg;

    // Pressure scale of the sensor readings. The limit register comes out of
    // reset at twenty times this value.
    localparam int unsigned PRESSURE_SCALE = 100;
    localparam logic [15:0] LIMIT_RESET    = 16'(20 * PRESSURE_SCALE);

    // Configuration register reset values.
    localparam logic [15:0] EXH_PERSIST_RESET   = 16'd15;
    localparam logic [15:0] NCPAP_PERSIST_RESET = 16'd200;
    localparam logic [15:0] EXH_SETTLE_RESET    = 16'd500;

    // Persistence counter saturates here.
    localparam logic [15:0] PERSIST_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_NCPAP_LIMIT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASELINE_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PEEP_OFFSET    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXH_PERSIST    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NCPAP_PERSIST  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_EXH_SETTLE     = 3'd5;

    // Item opcodes.
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Ventilation phases; the unused code counts as another phase.
    localparam logic [1:0] PHASE_OTHER = 2'd0;
    localparam logic [1:0] PHASE_EXH   = 2'd1;
    localparam logic [1:0] PHASE_NCPAP = 2'd2;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 24;

    typedef struct packed {
        logic signed [15:0] ncpap_limit;
        logic signed [15:0] baseline_limit;
        logic signed [15:0] peep_offset;
        logic [15:0]        exh_persist_ticks;
        logic [15:0]        ncpap_persist_ticks;
        logic [15:0]        exh_settle_time;
    } ehpd_cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         phase;
        logic [15:0]        phase_elapsed;
        logic signed [15:0] inh_pressure;
        logic signed [15:0] exh_pressure;
        logic [15:0]        inactive_load;
    } ehpd_item_t;

    typedef struct packed {
        logic [15:0]        inactive_count;
        logic [15:0]        persist_count;
        logic               fired_flag;
        logic               alarm_flag;
        logic signed [15:0] limit;
    } ehpd_state_t;

    typedef struct packed {
        logic               trigger_fired;
        logic               alarm_active;
        logic               alarm_raised;
        logic signed [15:0] active_limit;
    } ehpd_result_t;

endpackage

// File: design/ehpd_eval.sv
// ============================================================================
// ehpd_eval
// Single-pass evaluation of one item: threshold compare, persistence count,
// trigger and alarm flags, and the result word.
// ============================================================================
module ehpd_eval (
    input  ehpd_pkg::ehpd_cfg_t    cfg,
    input  ehpd_pkg::ehpd_item_t   item,
    input  ehpd_pkg::ehpd_state_t  state,
    output ehpd_pkg::ehpd_state_t  state_next,
    output ehpd_pkg::ehpd_result_t result
);
    import ehpd_pkg::*;

    logic               is_ncpap;
    logic signed [15:0] sel_limit;
    logic [15:0]        sel_need;
    logic signed [16:0] thr;
    logic               exceed;
    logic [15:0]        persist_inc;
    logic               reach;
    logic               settled;

    // Phase-selected limit and persistence requirement.
    assign is_ncpap  = (item.phase == PHASE_NCPAP);
    assign sel_limit = is_ncpap ? cfg.ncpap_limit : cfg.baseline_limit;
    assign sel_need  = is_ncpap ? cfg.ncpap_persist_ticks : cfg.exh_persist_ticks;

    // Threshold at full precision, then compare both readings against it.
    assign thr    = {sel_limit[15], sel_limit} + {cfg.peep_offset[15], cfg.peep_offset};
    assign exceed = ($signed({item.inh_pressure[15], item.inh_pressure}) > thr) ||
                    ($signed({item.exh_pressure[15], item.exh_pressure}) > thr);

    // Saturating increment of the persistence count.
    assign persist_inc = (state.persist_count != PERSIST_MAX) ?
                         state.persist_count + 16'd1 : state.persist_count;
    assign reach   = (persist_inc >= sel_need);
    assign settled = (item.phase_elapsed >= cfg.exh_settle_time);

    // Next state and result for the item.
    always_comb begin
        state_next           = state;
        result.trigger_fired = 1'b0;
        result.alarm_raised  = 1'b0;

        if (item.opcode == OP_LOAD) begin
            state_next.inactive_count = item.inactive_load;
        end else if (state.inactive_count != 16'd0) begin
            state_next.inactive_count = state.inactive_count - 16'd1;
        end else if (item.phase == PHASE_NCPAP ||
                     (item.phase == PHASE_EXH && settled)) begin
            state_next.limit = sel_limit;
            if (exceed) begin
                state_next.persist_count = persist_inc;
                if (reach) begin
                    // Exhalation restarts the count after each fire.
                    if (!is_ncpap) begin
                        state_next.persist_count = 16'd0;
                    end
                    state_next.fired_flag = 1'b1;
                    state_next.alarm_flag = 1'b1;
                    result.alarm_raised   = 1'b1;
                end
            end else begin
                state_next.persist_count = 16'd0;
                state_next.alarm_flag    = 1'b0;
            end
            result.trigger_fired = state_next.fired_flag;
        end else if (item.phase == PHASE_EXH) begin
            // Still settling: report the stored trigger only.
            result.trigger_fired = state.fired_flag;
        end else begin
            state_next.fired_flag = 1'b0;
        end

        result.alarm_active = state_next.alarm_flag;
        result.active_limit = state_next.limit;
    end

endmodule

// File: design/extreme_high_peep_detector.sv
// ============================================================================
// extreme_high_peep_detector
// Streaming extreme high PEEP detector with persistence and inactive countdown.
// ============================================================================
// Each accepted item is captured in an input register and evaluated into
// a result register that drives the result port, and the block sustains
// one item per clock while m_tready stays high. The detector state
// (countdown, persistence count, trigger and alarm flags, selected limit)
// lives in flip-flops updated by the evaluation step; that step and the
// output register set the rate. When m_tready is low the result register
// holds and one more item waits in the input register.
// Configuration is to be written through cfg_we/cfg_addr/cfg_wdata while idle; the block itself does not enforce this.
module extreme_high_peep_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [ehpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [15:0]                        cfg_wdata,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata from bit 0: phase_elapsed[15:0], inh_pressure[15:0],
    // exh_pressure[15:0], inactive_load[15:0]
    input  logic [ehpd_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser from bit 0: opcode[0], phase[1:0]
    input  logic [ehpd_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata from bit 0: trigger_fired, alarm_active, alarm_raised,
    // active_limit[15:0], then five zero bits
    output logic [ehpd_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ehpd_pkg::*;

    ehpd_cfg_t    cfg_reg;
    ehpd_item_t   item_reg;
    logic         in_valid_reg;
    ehpd_state_t  st_reg;
    ehpd_state_t  st_next;
    ehpd_result_t res_next;
    ehpd_result_t res_reg;
    logic         out_valid_reg;
    logic         out_advance;
    logic         go;

    // Pipeline control: the result register moves when empty or taken.
    assign out_advance = !out_valid_reg || m_tready;
    assign go          = in_valid_reg && out_advance;
    assign s_tready    = !in_valid_reg || out_advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ncpap_limit         <= '0;
            cfg_reg.baseline_limit      <= '0;
            cfg_reg.peep_offset         <= '0;
            cfg_reg.exh_persist_ticks   <= EXH_PERSIST_RESET;
            cfg_reg.ncpap_persist_ticks <= NCPAP_PERSIST_RESET;
            cfg_reg.exh_settle_time     <= EXH_SETTLE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NCPAP_LIMIT:    cfg_reg.ncpap_limit         <= cfg_wdata;
                REG_BASELINE_LIMIT: cfg_reg.baseline_limit      <= cfg_wdata;
                REG_PEEP_OFFSET:    cfg_reg.peep_offset         <= cfg_wdata;
                REG_EXH_PERSIST:    cfg_reg.exh_persist_ticks   <= cfg_wdata;
                REG_NCPAP_PERSIST:  cfg_reg.ncpap_persist_ticks <= cfg_wdata;
                REG_EXH_SETTLE:     cfg_reg.exh_settle_time     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode        <= s_tuser[0];
            item_reg.phase         <= s_tuser[2:1];
            item_reg.phase_elapsed <= s_tdata[15:0];
            item_reg.inh_pressure  <= s_tdata[31:16];
            item_reg.exh_pressure  <= s_tdata[47:32];
            item_reg.inactive_load <= s_tdata[63:48];
        end
    end

    ehpd_eval u_eval (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (st_reg),
        .state_next (st_next),
        .result     (res_next)
    );

    // Detector state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.inactive_count <= '0;
            st_reg.persist_count  <= '0;
            st_reg.fired_flag     <= 1'b0;
            st_reg.alarm_flag     <= 1'b0;
            st_reg.limit          <= LIMIT_RESET;
        end else if (go) begin
            st_reg <= st_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.active_limit, res_reg.alarm_raised,
                       res_reg.alarm_active, res_reg.trigger_fired};

`ifndef SYNTHESIS
    // A raised alarm always comes with the trigger and the active alarm.
    assert property (@(posedge aclk) disable iff (!aresetn)
        go && res_next.alarm_raised |=> res_reg.trigger_fired && res_reg.alarm_active)
        else $error("alarm raised without trigger and active alarm");

    // An evaluation tick during the countdown leaves the detector flags alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        go && item_reg.opcode == OP_EVAL && st_reg.inactive_count != 16'd0
        |=> $stable(st_reg.persist_count) && $stable(st_reg.fired_flag) &&
            $stable(st_reg.alarm_flag))
        else $error("detector state changed while inactive");

    // A fire in exhalation restarts the persistence count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        go && res_next.alarm_raised && item_reg.phase == PHASE_EXH
        |=> st_reg.persist_count == 16'd0)
        else $error("exhalation fire did not restart the count");

    // The alarm only sets together with a raised pulse.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(st_reg.alarm_flag) |-> $past(go && res_next.alarm_raised))
        else $error("alarm set without a fire");
`endif

endmodule
